>>> src/sfl_pkg.sv
// Shared types and constants for the sorted frequency list.
// No dependencies; imported by sfl_cell and sorted_frequency_list_unit.
`default_nettype none

package sfl_pkg;

   localparam int DEPTH   = 256;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int POS_W   = 8;
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int FREQ_W  = 32;
   localparam int TAG_W   = 9;
   localparam int COUNT_W = 9;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BAD_POS  = 2'd2
   } status_type;

   typedef struct packed {
      logic              operation;
      logic [FREQ_W-1:0] new_freq;
      logic [TAG_W-1:0]  new_tag;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
      logic               head_valid;
      logic [FREQ_W-1:0]  head_freq;
      logic [TAG_W-1:0]   head_tag;
   } rsp_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // Broadcast from the top level to every cell in the row.
   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type new_entry;
   } cell_ctl_type;

endpackage : sfl_pkg

`default_nettype wire

>>> src/sorted_frequency_list_unit.sv
// Top level of the sorted frequency list: a row of sfl_cell slots plus count and response logic.
// Depends on sfl_pkg and sfl_cell.
//
//   port group  direction  payload   handshake
//   req_        in         req_type  req_valid / req_stall
//   rsp_        out        rsp_type  rsp_valid / rsp_stall
//
// Each request is handled by all slots at once: they compare against the broadcast
// frequency in parallel and shift one place in the same edge, so a response is
// shown the cycle after the request and a new request can follow at once.
// Reset clears the count, the status and the response flag; slot contents are not reset.
// While a response is held by rsp_stall no further request is taken.
`default_nettype none

module sorted_frequency_list_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sfl_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sfl_pkg::rsp_type      rsp_data
);
   import sfl_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;

   logic             accept;
   logic             full;
   logic             pos_ok;
   cell_ctl_type     ctl;

   logic      [DEPTH-1:0] ge;
   entry_type [DEPTH-1:0] entry;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign pos_ok    = CMP_W'(req_data.position) < CMP_W'(count_ff);

   always_comb begin
      ctl.new_entry.freq = req_data.new_freq;
      ctl.new_entry.tag  = req_data.new_tag;
      ctl.ins            = accept && (req_data.operation == OP_INSERT) && !full;
      ctl.rem            = accept && (req_data.operation == OP_REMOVE) && pos_ok;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
      logic      occupied;
      logic      rem_here;
      logic      left_ge;
      entry_type left_entry;
      entry_type right_entry;

      assign occupied = IDX < CMP_W'(count_ff);
      assign rem_here = IDX >= CMP_W'(req_data.position);

      if (i == 0) begin : g_first
         assign left_ge    = 1'b0;
         assign left_entry = ctl.new_entry;
      end else begin : g_rest
         assign left_ge    = ge[i-1];
         assign left_entry = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = entry[i];
      end else begin : g_inner
         assign right_entry = entry[i+1];
      end

      sfl_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .is_head     (i == 0),
         .occupied    (occupied),
         .rem_here    (rem_here),
         .left_ge     (left_ge),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .ge          (ge[i]),
         .entry       (entry[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_DONE;
         if (req_data.operation == OP_INSERT) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (!pos_ok) begin
               status_in = STATUS_BAD_POS;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STATUS_DONE;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   // Head comes straight from the first slot; it cannot move while the response is held.
   always_comb begin
      rsp_data.status      = status_ff;
      rsp_data.entry_count = COUNT_W'(count_ff);
      rsp_data.head_valid  = count_ff != '0;
      rsp_data.head_freq   = rsp_data.head_valid ? entry[0].freq : '0;
      rsp_data.head_tag    = rsp_data.head_valid ? entry[0].tag  : '0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : sorted_frequency_list_unit

`default_nettype wire

>>> src/sfl_cell.sv
// One slot of the sorted row: holds an entry and compares it with the broadcast insert.
// Depends on sfl_pkg.
`default_nettype none

module sfl_cell (
   input  wire logic               clock,
   input  wire sfl_pkg::cell_ctl_type ctl,
   input  wire logic               is_head,
   input  wire logic               occupied,
   input  wire logic               rem_here,
   input  wire logic               left_ge,
   input  wire sfl_pkg::entry_type left_entry,
   input  wire sfl_pkg::entry_type right_entry,
   output logic                    ge,
   output sfl_pkg::entry_type      entry
);
   import sfl_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      load;

   // The head slot lets an equal insert pass behind it; later slots do not.
   always_comb begin
      if (!occupied) begin
         ge = 1'b1;
      end else if (is_head) begin
         ge = entry_ff.freq > ctl.new_entry.freq;
      end else begin
         ge = entry_ff.freq >= ctl.new_entry.freq;
      end
   end

   always_comb begin
      load     = 1'b0;
      entry_in = entry_ff;
      if (ctl.ins && ge) begin
         load     = 1'b1;
         entry_in = left_ge ? left_entry : ctl.new_entry;
      end else if (ctl.rem && rem_here) begin
         load     = 1'b1;
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule : sfl_cell

`default_nettype wire
